FILE: src/interleaved_subsequence_count_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the interleaved subsequence counter
// Shared property templates used by the checker.
// ----------------------------------------------------------------------------
`ifndef INTERLEAVED_SUBSEQUENCE_COUNT_UNIT_DEFINES_SVH
`define INTERLEAVED_SUBSEQUENCE_COUNT_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define ISC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ISC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg
// Types, constants and helpers of the interleaved subsequence counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package isc_pkg;

    localparam int MAX_A  = 32;
    localparam int MAX_B  = 32;
    localparam int MAX_C  = 16;
    localparam int MODE_W = 2;
    localparam int SYM_W  = 8;
    localparam int WAYS_W = 30;

    typedef logic [SYM_W-1:0]  t_sym;
    typedef logic [WAYS_W-1:0] t_ways;

    localparam t_ways WAYS_MOD = 30'd1000000007;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_A  = 2'd0,
        MODE_LOAD_B  = 2'd1,
        MODE_LOAD_C  = 2'd2,
        MODE_COMPUTE = 2'd3
    } t_mode;

    // a + b mod WAYS_MOD, both operands already reduced
    function automatic t_ways mod_add(input t_ways a, input t_ways b);
        logic [WAYS_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, WAYS_MOD}) begin
            sum = sum - {1'b0, WAYS_MOD};
        end
        return sum[WAYS_W-1:0];
    endfunction

endpackage

FILE: src/isc_if.sv
// ----------------------------------------------------------------------------
// isc_if
// Valid/ready channels of the counter: input words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface isc_in_if;
    logic                      valid;
    logic                      ready;
    logic [isc_pkg::MODE_W-1:0] mode;
    logic [isc_pkg::SYM_W-1:0]  symbol;

    modport source (output valid, output mode, output symbol, input ready);
    modport sink   (input valid, input mode, input symbol, output ready);
endinterface

interface isc_out_if;
    logic                       valid;
    logic                       ready;
    logic [isc_pkg::WAYS_W-1:0] ways;
    logic                       overflow;

    modport source (output valid, output ways, output overflow, input ready);
    modport sink   (input valid, input ways, input overflow, output ready);
endinterface

FILE: src/isc_ram.sv
// ----------------------------------------------------------------------------
// isc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/interleaved_subsequence_count_unit.sv
// Load words (A, B, C appends) are taken one per cycle while the block is idle.
// A compute word fills the prefix table; an empty C gives a result of one. The
// layer RAM port reads each table cell, then modifies and writes it back.
// One compute at a time.
// Reset clears lengths, overflow flag, FSM and output valid; RAM contents are
// left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
// interleaved_subsequence_count_unit
// Counts the ways to form C by merging subsequences of A and B, mod 1e9+7,
// filling the prefix table layer by layer out of a two-layer RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interleaved_subsequence_count_unit #(
    parameter int MAX_A = isc_pkg::MAX_A,
    parameter int MAX_B = isc_pkg::MAX_B,
    parameter int MAX_C = isc_pkg::MAX_C
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    isc_in_if.sink   i_in,
    isc_out_if.source o_out
);

    localparam int LEN_A_W    = $clog2(MAX_A + 1);
    localparam int LEN_B_W    = $clog2(MAX_B + 1);
    localparam int LEN_C_W    = $clog2(MAX_C + 1);
    localparam int A_AW       = (MAX_A > 1) ? $clog2(MAX_A) : 1;
    localparam int B_AW       = (MAX_B > 1) ? $clog2(MAX_B) : 1;
    localparam int C_AW       = (MAX_C > 1) ? $clog2(MAX_C) : 1;
    localparam int COL_DEPTH  = MAX_B + 1;
    localparam int LAYER_SIZE = (MAX_A + 1) * (MAX_B + 1);
    localparam int CELL_W     = $clog2(LAYER_SIZE);
    localparam int LAYER_DEPTH = 2 * LAYER_SIZE;
    localparam int LAYER_AW   = $clog2(LAYER_DEPTH);
    localparam logic [LAYER_AW-1:0] BANK1_BASE = LAYER_AW'(LAYER_SIZE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAYER,
        S_ROW,
        S_RD,
        S_WR,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [LEN_A_W-1:0]   r_len_a, n_len_a;
    logic [LEN_B_W-1:0]   r_len_b, n_len_b;
    logic [LEN_C_W-1:0]   r_len_c, n_len_c;
    logic                 r_dropped, n_dropped;
    logic [LEN_A_W-1:0]   r_x, n_x;
    logic [LEN_B_W-1:0]   r_y, n_y;
    logic [LEN_C_W-1:0]   r_z, n_z;
    logic [CELL_W-1:0]    r_cell, n_cell;
    logic                 r_bank, n_bank;
    isc_pkg::t_ways       r_sb, n_sb;
    isc_pkg::t_ways       r_last, n_last;
    logic                 r_out_valid, n_out_valid;
    isc_pkg::t_ways       r_out_ways, n_out_ways;
    logic                 r_out_overflow, n_out_overflow;

    // RAM controls
    logic                 a_we, b_we, c_we, a_re, b_re, c_re;
    logic                 l_we, l_re, col_we, col_re;
    logic [A_AW-1:0]      a_waddr;
    logic [B_AW-1:0]      b_waddr;
    logic [C_AW-1:0]      c_waddr;
    logic [LAYER_AW-1:0]  l_waddr, l_raddr;
    isc_pkg::t_sym        a_rdata, b_rdata, c_rdata;
    isc_pkg::t_ways       l_rdata, col_rdata;
    isc_pkg::t_ways       l_wdata, col_wdata;

    logic                 in_acc;
    isc_pkg::t_ways       prev_val, sa_val, cur_val;
    logic                 hit_a, hit_b;

    assign in_acc = i_in.valid && i_in.ready;

    assign a_waddr = r_len_a[A_AW-1:0];
    assign b_waddr = r_len_b[B_AW-1:0];
    assign c_waddr = r_len_c[C_AW-1:0];

    // write bank is r_bank, the previous layer sits in the other one
    assign l_waddr = (r_bank ? BANK1_BASE : '0) + LAYER_AW'(r_cell);
    assign l_raddr = (r_bank ? '0 : BANK1_BASE) + LAYER_AW'(r_cell);

    // layer zero is all ones; the column sum is empty on the first row
    assign prev_val = (r_z == '0) ? isc_pkg::t_ways'(1) : l_rdata;
    assign sa_val   = (r_x == '0) ? '0 : col_rdata;
    assign hit_a    = (a_rdata == c_rdata);
    assign hit_b    = (b_rdata == c_rdata);
    assign cur_val  = isc_pkg::mod_add(sa_val, r_sb);
    assign l_wdata  = cur_val;
    assign col_wdata = isc_pkg::mod_add(sa_val, hit_a ? prev_val : '0);

    isc_ram #(.WIDTH(isc_pkg::SYM_W), .DEPTH(MAX_A)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (i_in.symbol),
        .i_re    (a_re),
        .i_raddr (r_x[A_AW-1:0]),
        .o_rdata (a_rdata)
    );

    isc_ram #(.WIDTH(isc_pkg::SYM_W), .DEPTH(MAX_B)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (i_in.symbol),
        .i_re    (b_re),
        .i_raddr (r_y[B_AW-1:0]),
        .o_rdata (b_rdata)
    );

    isc_ram #(.WIDTH(isc_pkg::SYM_W), .DEPTH(MAX_C)) u_ram_c (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (i_in.symbol),
        .i_re    (c_re),
        .i_raddr (r_z[C_AW-1:0]),
        .o_rdata (c_rdata)
    );

    isc_ram #(.WIDTH(isc_pkg::WAYS_W), .DEPTH(LAYER_DEPTH)) u_ram_layer (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_re    (l_re),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    // running column sums over rows, one per y
    isc_ram #(.WIDTH(isc_pkg::WAYS_W), .DEPTH(COL_DEPTH)) u_ram_col (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (r_y),
        .i_wdata (col_wdata),
        .i_re    (col_re),
        .i_raddr (r_y),
        .o_rdata (col_rdata)
    );

    always_comb begin
        n_state        = r_state;
        n_len_a        = r_len_a;
        n_len_b        = r_len_b;
        n_len_c        = r_len_c;
        n_dropped      = r_dropped;
        n_x            = r_x;
        n_y            = r_y;
        n_z            = r_z;
        n_cell         = r_cell;
        n_bank         = r_bank;
        n_sb           = r_sb;
        n_last         = r_last;
        n_out_valid    = r_out_valid;
        n_out_ways     = r_out_ways;
        n_out_overflow = r_out_overflow;
        a_we   = 1'b0;
        b_we   = 1'b0;
        c_we   = 1'b0;
        a_re   = 1'b0;
        b_re   = 1'b0;
        c_re   = 1'b0;
        l_we   = 1'b0;
        l_re   = 1'b0;
        col_we = 1'b0;
        col_re = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (isc_pkg::t_mode'(i_in.mode))
                        isc_pkg::MODE_LOAD_A: begin
                            if (r_len_a < LEN_A_W'(MAX_A)) begin
                                a_we    = 1'b1;
                                n_len_a = r_len_a + LEN_A_W'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        isc_pkg::MODE_LOAD_B: begin
                            if (r_len_b < LEN_B_W'(MAX_B)) begin
                                b_we    = 1'b1;
                                n_len_b = r_len_b + LEN_B_W'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        isc_pkg::MODE_LOAD_C: begin
                            if (r_len_c < LEN_C_W'(MAX_C)) begin
                                c_we    = 1'b1;
                                n_len_c = r_len_c + LEN_C_W'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        isc_pkg::MODE_COMPUTE: begin
                            if (r_len_c == '0) begin
                                n_last  = isc_pkg::t_ways'(1);
                                n_state = S_DONE;
                            end else begin
                                n_z     = '0;
                                n_bank  = 1'b1;
                                n_state = S_LAYER;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LAYER: begin
                c_re    = 1'b1;
                n_x     = '0;
                n_cell  = '0;
                n_state = S_ROW;
            end
            S_ROW: begin
                a_re    = 1'b1;
                n_y     = '0;
                n_sb    = '0;
                n_state = S_RD;
            end
            S_RD: begin
                l_re    = 1'b1;
                b_re    = 1'b1;
                col_re  = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                l_we   = 1'b1;
                col_we = 1'b1;
                n_sb   = isc_pkg::mod_add(r_sb, hit_b ? prev_val : '0);
                n_last = cur_val;
                n_cell = r_cell + CELL_W'(1);
                if (r_y != r_len_b) begin
                    n_y     = r_y + LEN_B_W'(1);
                    n_state = S_RD;
                end else if (r_x != r_len_a) begin
                    n_x     = r_x + LEN_A_W'(1);
                    n_state = S_ROW;
                end else if ((r_z + LEN_C_W'(1)) != r_len_c) begin
                    n_z     = r_z + LEN_C_W'(1);
                    n_bank  = ~r_bank;
                    n_state = S_LAYER;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the result register to free up
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid    = 1'b1;
                    n_out_ways     = r_last;
                    n_out_overflow = r_dropped;
                    n_len_a        = '0;
                    n_len_b        = '0;
                    n_len_c        = '0;
                    n_dropped      = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len_a     <= '0;
            r_len_b     <= '0;
            r_len_c     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len_a     <= n_len_a;
            r_len_b     <= n_len_b;
            r_len_c     <= n_len_c;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
        r_x            <= n_x;
        r_y            <= n_y;
        r_z            <= n_z;
        r_cell         <= n_cell;
        r_bank         <= n_bank;
        r_sb           <= n_sb;
        r_last         <= n_last;
        r_out_ways     <= n_out_ways;
        r_out_overflow <= n_out_overflow;
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.ways     = r_out_ways;
    assign o_out.overflow = r_out_overflow;

endmodule

FILE: src/isc_checker.sv
// ----------------------------------------------------------------------------
// isc_checker
// Port-level checks of the counter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "interleaved_subsequence_count_unit_defines.svh"

module isc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic [isc_pkg::MODE_W-1:0] i_in_mode,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [isc_pkg::WAYS_W-1:0] i_out_ways,
    input logic                       i_out_overflow
);

    // a stalled result word keeps its value
    `ISC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_ways) && $stable(i_out_overflow), "result word changed while stalled")

    `ISC_ASSERT_IMPL(a_ways_range, i_clk, i_rst_n, i_out_valid, i_out_ways < isc_pkg::WAYS_MOD, "ways not reduced")

    // a compute word occupies the block
    `ISC_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_mode == isc_pkg::MODE_COMPUTE), !i_in_ready, "input taken during compute")

    // loads never produce a result
    `ISC_ASSERT_NEXT(a_load_quiet, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_mode != isc_pkg::MODE_COMPUTE), !$rose(i_out_valid), "result after load word")

endmodule

bind interleaved_subsequence_count_unit isc_checker u_isc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_mode      (i_in.mode),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_ways     (o_out.ways),
    .i_out_overflow (o_out.overflow)
);
